/* rtl/hlst_pkg.sv */
package hlst_pkg;

  // Default number of entries in the set.
  localparam int unsigned SET_DEPTH_DEF = 16;

  // Field widths of the request and result items.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned STACK_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HC_W    = 5;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_HELD = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

  // One held lock as stored in the table memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               is_write;
    logic [STACK_W-1:0] stack;
  } entry_t;

endpackage

/* rtl/held_lock_set_table.sv */
// Held lock set table: the set of locks held by one thread.
// Input channel (in_*): one request item per handshake; req_type selects
// acquire, release or clear. Result channel (out_*): exactly one item per
// request, carrying a status code and the number of locks held afterwards.
// Both channels move an item on a clock edge where valid is high and stall
// is low.
// Acquire, clear, the unused request type and a release on an empty set
// finish in the accept cycle; the result is registered and appears on the
// next cycle. Any other release scans the table from the newest entry down
// through one memory read port, one entry per cycle: a state to start the
// read, a scan state that compares the entries, a state that moves the last
// entry into the freed slot, and one to load the result register.
// One request is worked on at a time; the next one is taken once the
// sequencer is back in idle and the result register is free or draining.
// While the receiver stalls, the result register holds its item and the
// input channel stalls as well.
// Reset empties the set (count zero) and drops any pending result; the
// table memory itself is not cleared, since only entries below the count
// are ever read.
module held_lock_set_table #(
  parameter int unsigned SET_DEPTH = hlst_pkg::SET_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hlst_pkg::REQ_W-1:0]   in_req_type,
  input  logic [hlst_pkg::ID_W-1:0]    in_lock_id,
  input  logic                         in_is_write,
  input  logic [hlst_pkg::STACK_W-1:0] in_stack_handle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hlst_pkg::STAT_W-1:0]  out_status,
  output logic [hlst_pkg::HC_W-1:0]    out_held_count
);
  import hlst_pkg::*;

  localparam int unsigned IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              wr_mode_r, wr_mode_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [HC_W-1:0]   out_count_r, out_count_nxt;

  // Table memory with one write port and one registered read port.
  entry_t            mem [SET_DEPTH];
  entry_t            rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              in_accept;
  logic              out_free;
  logic [IW-1:0]     last_idx;
  logic              hit;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign last_idx  = IW'(count_r - CW'(1));
  assign hit       = (rd_data_r.id == id_r);

  // Sequencer: decode requests, scan the table and compact it on release.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    id_nxt         = id_r;
    wr_mode_nxt    = wr_mode_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_addr        = last_idx;
    wr_en          = 1'b0;
    wr_addr        = count_r[IW-1:0];
    wr_data        = '{id: in_lock_id, is_write: in_is_write, stack: in_stack_handle};

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          id_nxt      = in_lock_id;
          wr_mode_nxt = in_is_write;
          case (in_req_type)
            REQ_ACQUIRE: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(SET_DEPTH)) begin
                out_status_nxt = ST_FULL;
                out_count_nxt  = HC_W'(count_r);
              end else begin
                wr_en          = 1'b1;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = ST_OK;
                out_count_nxt  = HC_W'(count_r + CW'(1));
              end
            end
            REQ_RELEASE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOT_HELD;
                out_count_nxt  = HC_W'(count_r);
              end else begin
                // Start reading the newest entry.
                ptr_nxt   = last_idx;
                state_nxt = S_PRIME;
              end
            end
            REQ_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_count_nxt  = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_count_nxt  = HC_W'(count_r);
            end
          endcase
        end
      end
      S_PRIME: begin
        // Read data for the newest entry arrives on the next cycle.
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Compare one entry per cycle while the next one is read.
        if (hit) begin
          if (rd_data_r.is_write != wr_mode_r) begin
            status_nxt = ST_MISMATCH;
            state_nxt  = S_DONE;
          end else begin
            rd_addr   = last_idx;
            state_nxt = S_MOVE;
          end
        end else if (ptr_r == '0) begin
          status_nxt = ST_NOT_HELD;
          state_nxt  = S_DONE;
        end else begin
          rd_addr   = ptr_r - IW'(1);
          ptr_nxt   = ptr_r - IW'(1);
        end
      end
      S_MOVE: begin
        // Move the last entry into the released slot.
        wr_en      = 1'b1;
        wr_addr    = ptr_r;
        wr_data    = rd_data_r;
        count_nxt  = count_r - CW'(1);
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = HC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    id_r         <= id_nxt;
    wr_mode_r    <= wr_mode_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_held_count = out_count_r;

  // The count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SET_DEPTH))
    else $error("held count exceeds table depth");

  // The scan pointer always addresses a held entry.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CW'(ptr_r) < count_r)
    else $error("scan pointer outside held entries");

  // A compaction removes exactly one entry.
  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |=> count_r == $past(count_r) - CW'(1))
    else $error("compaction did not remove one entry");

  // No request is taken while a release is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRIME || state_r == S_SCAN || state_r == S_MOVE) |-> !in_accept)
    else $error("request accepted while busy");

  // A finished release is not lost while the result register is busy.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_free |=> state_r == S_DONE)
    else $error("pending result dropped");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hlst_pkg::*;

  // Request type that the block leaves undecoded.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned DEPTH        = SET_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1325;
  localparam int unsigned POOL_SIZE    = 10;
  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned QUIET_FIRST  = 400;
  localparam int unsigned QUIET_LAST   = 600;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [HC_W-1:0]   count;
  } lock_result_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [ID_W-1:0]    id;
    logic               wr;
    logic [STACK_W-1:0] stk;
    bit                 known;
    lock_result_t       result;
  } request_row_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   in_req_type     = REQ_ACQUIRE;
  logic [ID_W-1:0]    in_lock_id      = '0;
  logic               in_is_write     = 1'b0;
  logic [STACK_W-1:0] in_stack_handle = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [HC_W-1:0]    out_held_count;

  // Both sides stop idling while this is set.
  bit quiet = 1'b0;
  int unsigned error_count = 0;
  int unsigned silent_cycles = 0;

  lock_result_t pending_results[$];
  request_row_t directed_rows[$];
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  // Shadow copy of the held lock table.
  logic [ID_W-1:0]    shadow_id    [DEPTH];
  logic               shadow_wr    [DEPTH];
  logic [STACK_W-1:0] shadow_stack [DEPTH];
  int unsigned        shadow_count = 0;

  held_lock_set_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_lock_id      (in_lock_id),
    .in_is_write     (in_is_write),
    .in_stack_handle (in_stack_handle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_held_count  (out_held_count)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow table and return the result it gives.
  function automatic lock_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic [ID_W-1:0] id,
                                                 input logic wr,
                                                 input logic [STACK_W-1:0] stk);
    lock_result_t r;
    int n;
    int unsigned last;
    bit found;
    r.status = ST_OK;
    found = 1'b0;
    case (req)
      REQ_ACQUIRE: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_id[shadow_count] = id;
          shadow_wr[shadow_count] = wr;
          shadow_stack[shadow_count] = stk;
          shadow_count++;
        end
      end
      REQ_RELEASE: begin
        // Only the newest entry with this id decides the outcome.
        r.status = ST_NOT_HELD;
        for (n = int'(shadow_count) - 1; n >= 0 && !found; n--) begin
          if (shadow_id[n] == id) begin
            found = 1'b1;
            if (shadow_wr[n] != wr) begin
              r.status = ST_MISMATCH;
            end else begin
              r.status = ST_OK;
              last = shadow_count - 1;
              shadow_id[n] = shadow_id[last];
              shadow_wr[n] = shadow_wr[last];
              shadow_stack[n] = shadow_stack[last];
              shadow_count = last;
            end
          end
        end
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.count = HC_W'(shadow_count);
    return r;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                         input logic wr, input logic [STACK_W-1:0] stk,
                         input bit known, input logic [STAT_W-1:0] status,
                         input logic [HC_W-1:0] count);
    request_row_t row;
    row.req = req;
    row.id = id;
    row.wr = wr;
    row.stk = stk;
    row.known = known;
    row.result.status = status;
    row.result.count = count;
    directed_rows.push_back(row);
  endtask

  // Present one request item, wait for it to be taken, then record its result.
  task automatic send_request(input request_row_t row);
    lock_result_t predicted;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= row.req;
    in_lock_id <= row.id;
    in_is_write <= row.wr;
    in_stack_handle <= row.stk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(row.req, row.id, row.wr, row.stk);
    pending_results.push_back(row.known ? row.result : predicted);
  endtask

  // Stimulus: directed table first, then random request sequences.
  initial begin
    request_row_t row;
    int unsigned i;
    int unsigned pick;
    int unsigned sel;
    int unsigned slot;
    int unsigned acquire_pct;

    for (i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = {$urandom, $urandom};
    end

    // An error code on an empty set, then fill it to the top.
    add_row(REQ_RELEASE, 64'd5, 1'b0, 32'd0, 1, ST_NOT_HELD, 5'd0);
    add_row(REQ_ACQUIRE, 64'd0, 1'b0, 32'd0, 1, ST_OK, 5'd1);
    add_row(REQ_ACQUIRE, '1, 1'b1, '1, 1, ST_OK, 5'd2);
    add_row(REQ_ACQUIRE, 64'h8000_0000_0000_0000, 1'b0, 32'h8000_0000, 1, ST_OK, 5'd3);
    add_row(REQ_ACQUIRE, 64'd1, 1'b1, 32'd1, 1, ST_OK, 5'd4);
    add_row(REQ_ACQUIRE, 64'h5555_5555_5555_5555, 1'b0, 32'h5555_5555, 1, ST_OK, 5'd5);
    add_row(REQ_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 1, ST_OK, 5'd6);
    // The same lock held twice, write first and read second.
    add_row(REQ_ACQUIRE, 64'hABC, 1'b1, 32'h100, 1, ST_OK, 5'd7);
    add_row(REQ_ACQUIRE, 64'hABC, 1'b0, 32'h200, 1, ST_OK, 5'd8);
    for (i = 9; i <= DEPTH; i++) begin
      add_row(REQ_ACQUIRE, 64'h1000 + i, i[0], 32'h3000 + i, 1, ST_OK, HC_W'(i));
    end
    add_row(REQ_ACQUIRE, 64'h77, 1'b0, 32'h77, 1, ST_FULL, HC_W'(DEPTH));
    add_row(REQ_RELEASE, '1, 1'b0, 32'd0, 1, ST_MISMATCH, HC_W'(DEPTH));
    // Newest duplicate is a read lock, so a write release is refused.
    add_row(REQ_RELEASE, 64'hABC, 1'b1, 32'd0, 0, ST_OK, 5'd0);
    add_row(REQ_RELEASE, 64'hABC, 1'b0, 32'd0, 0, ST_OK, 5'd0);
    add_row(REQ_RELEASE, 64'd0, 1'b0, '1, 0, ST_OK, 5'd0);
    add_row(REQ_RELEASE, 64'h1234, 1'b1, 32'd0, 0, ST_OK, 5'd0);
    add_row(REQ_UNUSED, '1, 1'b1, '1, 0, ST_OK, 5'd0);
    add_row(REQ_CLEAR, 64'd0, 1'b0, 32'd0, 1, ST_OK, 5'd0);
    add_row(REQ_ACQUIRE, 64'd0, 1'b1, 32'd9, 1, ST_OK, 5'd1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k]);
    end

    // Random part: mostly acquires of pooled ids and releases of held ones.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
      acquire_pct = ((i / 150) % 2 == 0) ? 65 : 35;
      pick = $urandom_range(99);
      row.known = 0;
      row.result.status = ST_OK;
      row.result.count = '0;
      row.wr = 1'($urandom_range(1));
      row.stk = $urandom;
      row.id = {$urandom, $urandom};
      if (pick < 2) begin
        row.req = REQ_CLEAR;
      end else if (pick < 4) begin
        row.req = REQ_UNUSED;
      end else if (pick < 4 + acquire_pct) begin
        row.req = REQ_ACQUIRE;
        if ($urandom_range(99) < 60) row.id = id_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        row.req = REQ_RELEASE;
        sel = $urandom_range(99);
        if (shadow_count > 0 && sel < 85) begin
          slot = $urandom_range(shadow_count - 1);
          row.id = shadow_id[slot];
          row.wr = (sel < 75) ? shadow_wr[slot] : !shadow_wr[slot];
        end else if (sel < 95) begin
          row.id = id_pool[$urandom_range(POOL_SIZE - 1)];
        end
      end
      send_request(row);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Result side: compare each taken item with the oldest expectation.
  always @(posedge clk) begin : result_check
    lock_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected: status %0d count %0d",
                 $time, out_status, out_held_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_held_count !== want.count) begin
          $display("%0t: held count expected %0d actual %0d",
                   $time, want.count, out_held_count);
          error_count++;
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      silent_cycles <= 0;
    end else if (silent_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, silent_cycles);
      $display("testbench NOT OK");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

endmodule

/* filelist.f */
rtl/hlst_pkg.sv
rtl/held_lock_set_table.sv
sim/testbench.sv
